@@ rtl/fbl_pkg.sv @@
// ----------------------------------------------------------------------------
// fbl_pkg
// Shared types and constants of the frame block locator: register indexes,
// request commands, response status codes and the control/status bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fbl_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // Header bytes ahead of the block index, and bytes per index entry (log2).
   localparam int HDR_BYTES         = 32;
   localparam int ENTRY_BYTES_LOG2  = 3;

   localparam int ENTRY_WIDTH = 64;   // {first frame, byte size}

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_DATA_OFFSET   = 3'd0,
      REG_CHANNEL_COUNT = 3'd1,
      REG_FRAME_COUNT   = 3'd2,
      REG_COMPRESSED    = 3'd3,
      REG_BLOCK_COUNT   = 3'd4,
      REG_FILE_LENGTH   = 3'd5
   } csr_reg_type;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_SHORT = 2'd2
   } status_type;

   // Controller -> datapath
   typedef struct packed {
      logic load;      // write accepted load request into the index store
      logic init;      // latch query frame, clear the walk state
      logic issue;     // read the next index entry
      logic process;   // index entry read data is valid
      logic finish;    // write the response registers
   } dp_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic early;       // answered without walking the index
      logic found;       // walk has matched a block
      logic issue_done;  // every entry in use has been read
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/frame_block_locator.sv @@
// ----------------------------------------------------------------------------
// frame_block_locator
// Compressed-block index of a sequence file: loads index entries and answers
// which block holds a frame, with its first frame, length, offset and size.
// ----------------------------------------------------------------------------
//  channel   ports      direction  carries
//  request   req_*      in         load index entry / query frame
//  response  rsp_*      out        status and block description per query
//  csr       csr_*      in         register writes, no read-back
//
//  A load gives no response.
//  A query reads at most limit index entries, limit = min(block_count, MAX_BLOCKS):
//  the walk reads one index entry per cycle from the single read port of the
//  index RAM and stops early once the block is found.
//  Out-of-range, uncompressed and short-file queries answer without a walk.
//  The index RAM is not cleared by reset; the response register decouples
//  a stalled consumer until the next query's answer is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_block_locator #(
   parameter int MAX_BLOCKS = 4096
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [fbl_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [fbl_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_command,
   input  wire logic [11:0]                         req_entry_index,
   input  wire logic [31:0]                         req_entry_first_frame,
   input  wire logic [31:0]                         req_entry_size,
   input  wire logic [31:0]                         req_frame,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_status,
   output logic [31:0]                              rsp_block_first_frame,
   output logic [31:0]                              rsp_block_frames,
   output logic [31:0]                              rsp_block_offset,
   output logic [31:0]                              rsp_block_size
);

   import fbl_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   fbl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   fbl_dp #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_entry_index       (req_entry_index),
      .req_entry_first_frame (req_entry_first_frame),
      .req_entry_size        (req_entry_size),
      .req_frame             (req_frame),
      .cmd                   (cmd),
      .status                (status),
      .rsp_status            (rsp_status),
      .rsp_block_first_frame (rsp_block_first_frame),
      .rsp_block_frames      (rsp_block_frames),
      .rsp_block_offset      (rsp_block_offset),
      .rsp_block_size        (rsp_block_size)
   );

endmodule

`default_nettype wire

@@ rtl/fbl_ram.sv @@
// ----------------------------------------------------------------------------
// fbl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fbl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/fbl_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbl_ctrl
// Sequencer of the frame block locator: request handshake, index walk
// scheduling and the response valid register.
// ----------------------------------------------------------------------------
`default_nettype none

module fbl_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_command,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire fbl_pkg::dp_status_type status,
   output fbl_pkg::dp_cmd_type         cmd
);

   import fbl_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_WALK,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      pend_ff, pend_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.load     = accept && (req_command == CMD_LOAD);
      cmd.init     = accept && (req_command == CMD_QUERY);
      cmd.process  = pend_ff && (state_ff == S_WALK);
      case (state_ff)
         S_IDLE: begin
            if (cmd.init) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = status.early ? S_FINISH : S_WALK;
         end
         S_WALK: begin
            cmd.issue = !status.found && !status.issue_done;
            if (status.found || (status.issue_done && !pend_ff)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold the answer until the response register drains
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      pend_in = cmd.issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/fbl_dp.sv @@
// ----------------------------------------------------------------------------
// fbl_dp
// Datapath of the frame block locator: configuration registers, block index
// store, walk state (running offset, previous non-empty entry) and the
// response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fbl_dp #(
   parameter int MAX_BLOCKS = 4096
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write,
   input  wire logic [fbl_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [fbl_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  wire logic [11:0]                            req_entry_index,
   input  wire logic [31:0]                            req_entry_first_frame,
   input  wire logic [31:0]                            req_entry_size,
   input  wire logic [31:0]                            req_frame,
   input  wire fbl_pkg::dp_cmd_type                    cmd,
   output fbl_pkg::dp_status_type                      status,
   output logic [1:0]                                  rsp_status,
   output logic [31:0]                                 rsp_block_first_frame,
   output logic [31:0]                                 rsp_block_frames,
   output logic [31:0]                                 rsp_block_offset,
   output logic [31:0]                                 rsp_block_size
);

   import fbl_pkg::*;

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [12:0] LIMIT_MAX = 13'(MAX_BLOCKS);

   // configuration
   logic [15:0] data_offset_ff;
   logic [31:0] channel_count_ff;
   logic [31:0] frame_count_ff;
   logic        compressed_ff;
   logic [11:0] block_count_ff;
   logic [31:0] file_length_ff;

   // walk state
   logic [31:0]   q_ff;
   logic [CW-1:0] cnt_ff;
   logic [31:0]   off_ff;
   logic [31:0]   prev_first_ff;
   logic [31:0]   prev_size_ff;
   logic          have_prev_ff;
   logic          found_ff;
   logic [31:0]   match_first_ff;
   logic [31:0]   match_frames_ff;
   logic [31:0]   match_size_ff;

   logic [ENTRY_WIDTH-1:0] rd_data;
   logic [31:0]            ent_first;
   logic [31:0]            ent_size;
   logic                   wr_en;
   logic [12:0]            limit;
   logic [15:0]            need_bytes;
   logic                   range_err;
   logic                   short_file;
   logic                   take;
   logic                   hit;

   status_type  fin_status;
   logic [31:0] fin_first;
   logic [31:0] fin_frames;
   logic [31:0] fin_offset;
   logic [31:0] fin_size;

   assign wr_en = cmd.load && ({1'b0, req_entry_index} < LIMIT_MAX);

   fbl_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (MAX_BLOCKS)
   ) u_index (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_entry_index[AW-1:0]),
      .wr_data ({req_entry_first_frame, req_entry_size}),
      .rd_en   (cmd.issue),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign ent_first = rd_data[63:32];
   assign ent_size  = rd_data[31:0];

   assign limit      = ({1'b0, block_count_ff} < LIMIT_MAX) ? {1'b0, block_count_ff} : LIMIT_MAX;
   assign need_bytes = 16'(HDR_BYTES) + (16'(block_count_ff) << ENTRY_BYTES_LOG2);
   assign range_err  = (q_ff >= frame_count_ff);
   assign short_file = (file_length_ff < {16'd0, need_bytes});

   assign status.early      = range_err || !compressed_ff || short_file;
   assign status.found      = found_ff;
   assign status.issue_done = (13'(cnt_ff) == limit);

   // a non-empty entry either closes the previous block around the query or
   // becomes the new previous block
   assign take = cmd.process && !found_ff && (ent_size != 32'd0);
   assign hit  = have_prev_ff && (q_ff >= prev_first_ff) && (q_ff < ent_first);

   always_ff @(posedge clock) begin
      if (reset) begin
         data_offset_ff   <= '0;
         channel_count_ff <= '0;
         frame_count_ff   <= '0;
         compressed_ff    <= 1'b0;
         block_count_ff   <= '0;
         file_length_ff   <= '0;
         have_prev_ff     <= 1'b0;
         found_ff         <= 1'b0;
         cnt_ff           <= '0;
      end else begin
         if (csr_write) begin
            case (csr_reg_type'(csr_index))
               REG_DATA_OFFSET:   data_offset_ff   <= csr_wdata[15:0];
               REG_CHANNEL_COUNT: channel_count_ff <= csr_wdata;
               REG_FRAME_COUNT:   frame_count_ff   <= csr_wdata;
               REG_COMPRESSED:    compressed_ff    <= csr_wdata[0];
               REG_BLOCK_COUNT:   block_count_ff   <= csr_wdata[11:0];
               REG_FILE_LENGTH:   file_length_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.init) begin
            have_prev_ff <= 1'b0;
            found_ff     <= 1'b0;
            cnt_ff       <= '0;
         end else begin
            if (cmd.issue) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            if (take) begin
               if (hit) begin
                  found_ff <= 1'b1;
               end else begin
                  have_prev_ff <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         q_ff   <= req_frame;
         off_ff <= {16'd0, data_offset_ff};
      end else if (take) begin
         if (hit) begin
            match_first_ff  <= prev_first_ff;
            match_frames_ff <= ent_first - prev_first_ff;
            match_size_ff   <= prev_size_ff;
         end else begin
            if (have_prev_ff) begin
               off_ff <= off_ff + prev_size_ff;
            end
            prev_first_ff <= ent_first;
            prev_size_ff  <= ent_size;
         end
      end
   end

   always_comb begin
      fin_status = ST_RANGE;
      fin_first  = '0;
      fin_frames = '0;
      fin_offset = '0;
      fin_size   = '0;
      if (range_err) begin
         fin_status = ST_RANGE;
      end else if (!compressed_ff) begin
         fin_status = ST_OK;
         fin_frames = frame_count_ff;
         fin_offset = {16'd0, data_offset_ff};
         fin_size   = 32'(channel_count_ff * frame_count_ff);
      end else if (short_file) begin
         fin_status = ST_SHORT;
      end else if (found_ff) begin
         fin_status = ST_OK;
         fin_first  = match_first_ff;
         fin_frames = match_frames_ff;
         fin_offset = off_ff;
         fin_size   = match_size_ff;
      end else if (have_prev_ff && (q_ff >= prev_first_ff)) begin
         // last non-empty block runs to the end of the sequence
         fin_status = ST_OK;
         fin_first  = prev_first_ff;
         fin_frames = frame_count_ff - prev_first_ff;
         fin_offset = off_ff;
         fin_size   = prev_size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status            <= fin_status;
         rsp_block_first_frame <= fin_first;
         rsp_block_frames      <= fin_frames;
         rsp_block_offset      <= fin_offset;
         rsp_block_size        <= fin_size;
      end
   end

endmodule

`default_nettype wire

@@ rtl/fbl_checker.sv @@
// ----------------------------------------------------------------------------
// fbl_checker
// Port-level checks of the frame block locator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fbl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [31:0] rsp_block_first_frame,
   input wire logic [31:0] rsp_block_frames,
   input wire logic [31:0] rsp_block_offset,
   input wire logic [31:0] rsp_block_size
);

   import fbl_pkg::*;

   a_reset_clears_rsp : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_block_offset) && $stable(rsp_block_size))
      else $error("stalled response changed");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_RANGE)
         || (rsp_status == ST_SHORT))
      else $error("undefined response status");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_block_first_frame == '0)
         && (rsp_block_frames == '0) && (rsp_block_offset == '0)
         && (rsp_block_size == '0))
      else $error("error response carries block data");

   // the queried frame lies inside the answered block, so it is never empty
   a_ok_frames : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) |-> (rsp_block_frames != '0))
      else $error("ok response with zero frames");

endmodule

bind frame_block_locator fbl_checker u_fbl_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_status            (rsp_status),
   .rsp_block_first_frame (rsp_block_first_frame),
   .rsp_block_frames      (rsp_block_frames),
   .rsp_block_offset      (rsp_block_offset),
   .rsp_block_size        (rsp_block_size)
);

`default_nettype wire
